// ===== src/ltrie_pkg.sv =====
// Shared types, codes and helpers of the left-to-right integer expression block.
package ltrie_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CharW = 8;
  localparam int unsigned ErrW  = 2;

  localparam logic [DataW-1:0] NumMax = 32'h7FFF_FFFF;

  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChStar  = 8'h2A;
  localparam logic [CharW-1:0] ChSlash = 8'h2F;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  typedef enum logic [2:0] {
    OP_FIRST = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_OTHER = 3'd5
  } ltrie_op_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 2'd0,
    ERR_MALFORMED = 2'd1,
    ERR_RANGE     = 2'd2,
    ERR_DIVZERO   = 2'd3
  } ltrie_err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FINAL,
    ST_APPLY,
    ST_MUL_WB,
    ST_DIV_WAIT,
    ST_DONE_APPLY,
    ST_FINISH
  } ltrie_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic digit;
    logic err_malformed;
    logic apply_simple;
    logic mul_start;
    logic mul_wb;
    logic div_zero;
    logic div_start;
    logic div_wb;
    logic new_op;
    logic load_out;
  } ltrie_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic      is_digit;
    logic      last;
    logic      in_number;
    logic      err_set;
    ltrie_op_e pend_op;
    logic      acc_zero;
    logic      div_done;
    logic      out_busy;
  } ltrie_status_t;

  function automatic ltrie_op_e op_code(input logic [CharW-1:0] ch);
    ltrie_op_e op;
    unique case (ch)
      ChPlus:  op = OP_ADD;
      ChMinus: op = OP_SUB;
      ChStar:  op = OP_MUL;
      ChSlash: op = OP_DIV;
      default: op = OP_OTHER;
    endcase
    return op;
  endfunction

endpackage

// ===== src/ltrie_div.sv =====
// Iterative signed-by-positive divider, one quotient bit per cycle.
module ltrie_div
  import ltrie_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DataW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DataW);
  localparam logic [CntW-1:0] CntLast = CntW'(DataW - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             neg_q, neg_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] dsr_q, dsr_d;

  logic [DataW:0]   shifted;
  logic [DataW+1:0] diff;

  assign shifted = {rem_q, quo_q[DataW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = dividend_i[DataW-1];
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i[DataW-1] ? (~dividend_i + DataW'(1)) : dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // Restoring step: keep the difference when it does not borrow.
      if (!diff[DataW+1]) begin
        rem_d = diff[DataW-1:0];
      end else begin
        rem_d = shifted[DataW-1:0];
      end
      quo_d = {quo_q[DataW-2:0], ~diff[DataW+1]};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + DataW'(1)) : quo_q;

endmodule

// ===== src/ltrie_dp.sv =====
// Datapath: number builder, running value, multiplier, divider and output register.
module ltrie_dp
  import ltrie_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ltrie_cmd_t       cmd_i,
  output ltrie_status_t    status_o,
  input  logic [CharW-1:0] char_i,
  input  logic             last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] out_value_o,
  output logic [ErrW-1:0]  out_error_o,
  output logic             div_busy_o
);

  logic [CharW-1:0] ch_q;
  logic             last_q;
  logic [DataW-1:0] accum_q, accum_d;
  logic [DataW-1:0] rv_q, rv_d;
  logic [DataW-1:0] prod_q;
  ltrie_op_e        pend_q, pend_d;
  logic             innum_q, innum_d;
  ltrie_err_e       err_q, err_d;
  logic             ovalid_q, ovalid_d;
  logic [DataW-1:0] oval_q;
  ltrie_err_e       oerr_q;

  logic [CharW-1:0] digit_full;
  logic [3:0]       digit;
  logic [DataW+3:0] times_ten;
  logic             div_done;
  logic [DataW-1:0] quotient;

  assign digit_full = ch_q - ChZero;
  assign digit      = digit_full[3:0];
  assign times_ten  = {accum_q, 3'b000} + {2'b00, accum_q, 1'b0} + {{DataW{1'b0}}, digit};

  ltrie_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rv_q),
    .divisor_i  (accum_q),
    .busy_o     (div_busy_o),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    accum_d = accum_q;
    rv_d    = rv_q;
    pend_d  = pend_q;
    innum_d = innum_q;
    err_d   = err_q;
    if (cmd_i.digit) begin
      if (!innum_q) begin
        accum_d = {{(DataW-4){1'b0}}, digit};
        innum_d = 1'b1;
      end else if (times_ten > {4'b0000, NumMax}) begin
        err_d = ERR_RANGE;
      end else begin
        accum_d = times_ten[DataW-1:0];
      end
    end
    if (cmd_i.err_malformed) begin
      err_d = ERR_MALFORMED;
    end
    if (cmd_i.div_zero) begin
      err_d = ERR_DIVZERO;
    end
    if (cmd_i.apply_simple) begin
      case (pend_q)
        OP_FIRST: rv_d = accum_q;
        OP_ADD:   rv_d = rv_q + accum_q;
        OP_SUB:   rv_d = rv_q - accum_q;
        default:  rv_d = rv_q;
      endcase
    end
    if (cmd_i.mul_wb) begin
      rv_d = prod_q;
    end
    if (cmd_i.div_wb) begin
      rv_d = quotient;
    end
    if (cmd_i.new_op) begin
      pend_d  = op_code(ch_q);
      innum_d = 1'b0;
      accum_d = '0;
    end
    if (cmd_i.load_out) begin
      // Clear all expression state for the next one.
      accum_d = '0;
      rv_d    = '0;
      pend_d  = OP_FIRST;
      innum_d = 1'b0;
      err_d   = ERR_NONE;
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_i.load_out) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q  <= '0;
      rv_q     <= '0;
      pend_q   <= OP_FIRST;
      innum_q  <= 1'b0;
      err_q    <= ERR_NONE;
      ovalid_q <= 1'b0;
    end else begin
      accum_q  <= accum_d;
      rv_q     <= rv_d;
      pend_q   <= pend_d;
      innum_q  <= innum_d;
      err_q    <= err_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      ch_q   <= char_i;
      last_q <= last_i;
    end
    if (cmd_i.mul_start) begin
      prod_q <= rv_q * accum_q;
    end
    if (cmd_i.load_out) begin
      oval_q <= (err_q == ERR_NONE) ? rv_q : '0;
      oerr_q <= err_q;
    end
  end

  always_comb begin
    status_o.is_digit  = (ch_q >= ChZero) && (ch_q <= ChNine);
    status_o.last      = last_q;
    status_o.in_number = innum_q;
    status_o.err_set   = (err_q != ERR_NONE);
    status_o.pend_op   = pend_q;
    status_o.acc_zero  = (accum_q == '0);
    status_o.div_done  = div_done;
    status_o.out_busy  = ovalid_q && !out_ready_i;
  end

  assign out_valid_o = ovalid_q;
  assign out_value_o = oval_q;
  assign out_error_o = oerr_q;

endmodule

// ===== src/ltrie_ctrl.sv =====
// Controller state machine: sequences each character through the datapath.
module ltrie_ctrl
  import ltrie_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ltrie_status_t status_i,
  output ltrie_cmd_t    cmd_o
);

  ltrie_state_e state_q, state_d;
  logic         fin_q, fin_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.err_set) begin
          state_d = status_i.last ? ST_FINISH : ST_IDLE;
        end else if (status_i.is_digit) begin
          state_d = status_i.last ? ST_FINAL : ST_IDLE;
        end else if (!status_i.in_number) begin
          state_d = status_i.last ? ST_FINISH : ST_IDLE;
        end else begin
          state_d = ST_APPLY;
          fin_d   = 1'b0;
        end
      end
      ST_FINAL: begin
        if (status_i.err_set || !status_i.in_number) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_APPLY;
          fin_d   = 1'b1;
        end
      end
      ST_APPLY: begin
        if (status_i.pend_op == OP_MUL) begin
          state_d = ST_MUL_WB;
        end else if (status_i.pend_op == OP_DIV && !status_i.acc_zero) begin
          state_d = ST_DIV_WAIT;
        end else begin
          state_d = ST_DONE_APPLY;
        end
      end
      ST_MUL_WB: state_d = ST_DONE_APPLY;
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_DONE_APPLY;
        end
      end
      ST_DONE_APPLY: begin
        if (fin_q) begin
          state_d = ST_FINISH;
        end else begin
          state_d = status_i.last ? ST_FINAL : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_DECODE: begin
        if (!status_i.err_set) begin
          if (status_i.is_digit) begin
            cmd_o.digit = 1'b1;
          end else if (!status_i.in_number) begin
            cmd_o.err_malformed = 1'b1;
          end
        end
      end
      ST_FINAL: begin
        if (!status_i.err_set && !status_i.in_number) begin
          cmd_o.err_malformed = 1'b1;
        end
      end
      ST_APPLY: begin
        if (status_i.pend_op == OP_MUL) begin
          cmd_o.mul_start = 1'b1;
        end else if (status_i.pend_op == OP_DIV) begin
          cmd_o.div_zero  = status_i.acc_zero;
          cmd_o.div_start = !status_i.acc_zero;
        end else begin
          cmd_o.apply_simple = 1'b1;
        end
      end
      ST_MUL_WB:   cmd_o.mul_wb = 1'b1;
      ST_DIV_WAIT: cmd_o.div_wb = status_i.div_done;
      ST_DONE_APPLY: cmd_o.new_op = !fin_q;
      ST_FINISH:   cmd_o.load_out = !status_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

endmodule

// ===== src/left_to_right_integer_expression.sv =====
// Sequencing: a digit beat passes through decode; an operator beat applying +, - or the
// first number goes through decode, apply and done-apply; * adds a multiply write-back
// and / a wait on the divider unless the divisor is zero. A last beat adds a final apply
// and a finish state, where the result is loaded once the output register is free.
// Throughput: one character at a time; input also waits while a finished result sits in
// a full output register. Reset (rst_ni low, async) clears the control and expression
// state and the output valid flag; the data registers are not reset.
module left_to_right_integer_expression
  import ltrie_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input beat: character
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [CharW-1:0] s_tdata_i,   // [7:0] character
  input  logic             s_tlast_i,   // last_char
  // Result beat
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [DataW-1:0] m_tdata_o,   // [31:0] value
  output logic [ErrW-1:0]  m_tuser_o    // [1:0] error
);

  ltrie_cmd_t    cmd;
  ltrie_status_t status;
  logic          div_busy;

  // Controller: one character at a time through decode, apply and finish.
  ltrie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: holds the expression state and the result register.
  ltrie_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .char_i      (s_tdata_i),
    .last_i      (s_tlast_i),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_value_o (m_tdata_o),
    .out_error_o (m_tuser_o),
    .div_busy_o  (div_busy)
  );

`ifndef SYNTHESIS
  // A result with an error carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_tuser_o != ERR_NONE)) |-> (m_tdata_o == '0))
    else $error("error result with nonzero value");

  // Never take a character while a division is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o |-> !div_busy)
    else $error("input ready during division");

  // Each accepted beat is processed before the next is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !s_tready_o)
    else $error("two beats accepted back to back");

  // A result is loaded only into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_tvalid_o || m_tready_i))
    else $error("result overwrote pending output");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the left-to-right integer expression block: predictor, stimulus and checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ltrie_pkg::*;

  typedef logic [CharW-1:0] char_q_t[$];

  typedef struct {
    logic [DataW-1:0] total;
    ltrie_err_e       err;
  } expr_result_t;

  localparam int HoldOffCycles = 500;
  localparam int DrainCycles   = 60;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             s_tvalid_i = 1'b0;
  logic             s_tready_o;
  logic [CharW-1:0] s_tdata_i  = '0;  // [7:0] character
  logic             s_tlast_i  = 1'b0;  // last_char
  logic             m_tvalid_o;
  logic             m_tready_i = 1'b0;
  logic [DataW-1:0] m_tdata_o;  // [31:0] value
  logic [ErrW-1:0]  m_tuser_o;  // [1:0] error

  // Idle percentages and the receiver hold-off, changed by the test sequence.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          hold_cycles   = 0;

  int chars_sent      = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int err_seen[4]     = '{default: 0};

  // Predicted results not yet seen on the master side, oldest first.
  expr_result_t pending_results[$];

  // Predictor state for the expression in flight.
  logic [DataW-1:0] acc_number;
  logic [DataW-1:0] run_total;
  ltrie_op_e        queued_op;
  logic             mid_number;
  ltrie_err_e       expr_err;

  left_to_right_integer_expression dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(20ms);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_expression();
    acc_number = '0;
    run_total  = '0;
    queued_op  = OP_FIRST;
    mid_number = 1'b0;
    expr_err   = ERR_NONE;
  endfunction

  function automatic ltrie_op_e char_to_op(logic [CharW-1:0] ch);
    case (ch)
      ChPlus:  return OP_ADD;
      ChMinus: return OP_SUB;
      ChStar:  return OP_MUL;
      ChSlash: return OP_DIV;
      default: return OP_OTHER;
    endcase
  endfunction

  // Fold the finished number into the running total with the queued operator.
  function automatic void fold_number();
    int dividend;
    int divisor;
    case (queued_op)
      OP_FIRST: run_total = acc_number;
      OP_ADD:   run_total = run_total + acc_number;
      OP_SUB:   run_total = run_total - acc_number;
      OP_MUL:   run_total = run_total * acc_number;
      OP_DIV: begin
        if (acc_number == '0) begin
          expr_err = ERR_DIVZERO;
        end else begin
          // divisor never exceeds 2^31-1, so the quotient cannot overflow
          dividend  = run_total;
          divisor   = acc_number;
          run_total = dividend / divisor;
        end
      end
      default: ;  // unknown operator: drop the number
    endcase
  endfunction

  function automatic void predict_char(logic [CharW-1:0] ch, logic is_last);
    longint unsigned grown;
    expr_result_t    res;
    if (expr_err == ERR_NONE) begin
      if (ch >= ChZero && ch <= ChNine) begin
        if (!mid_number) begin
          acc_number = DataW'(ch - ChZero);
          mid_number = 1'b1;
        end else begin
          grown = 64'(acc_number) * 10 + 64'(ch - ChZero);
          if (grown > 64'(NumMax)) expr_err = ERR_RANGE;
          else acc_number = grown[DataW-1:0];
        end
      end else if (!mid_number) begin
        expr_err = ERR_MALFORMED;
      end else begin
        fold_number();
        queued_op  = char_to_op(ch);
        mid_number = 1'b0;
        acc_number = '0;
      end
    end
    if (is_last) begin
      if (expr_err == ERR_NONE) begin
        if (!mid_number) expr_err = ERR_MALFORMED;
        else fold_number();
      end
      res.total = (expr_err == ERR_NONE) ? run_total : '0;
      res.err   = expr_err;
      pending_results.insert(pending_results.size(), res);
      clear_expression();
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // Entered and left at a falling edge; valid stays high on return so that
  // back-to-back beats never lower and raise it in one step.
  task automatic send_char(input logic [CharW-1:0] ch, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= ch;
    s_tlast_i  <= is_last;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    predict_char(ch, is_last);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_expression(input char_q_t text);
    for (int i = 0; i < text.size(); i++) begin
      send_char(text[i], i == text.size() - 1);
    end
  endtask

  // Receiver: honor a pending hold-off first, otherwise stall at random.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_tready_i <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare every result beat against the oldest prediction.
  always @(posedge clk_i) begin
    expr_result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result beat, value=%0d error=%0d",
                   $realtime, $signed(m_tdata_o), m_tuser_o);
        end
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        err_seen[want.err]++;
        if (m_tdata_o !== want.total || m_tuser_o !== want.err) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result %0d mismatch%s%s: expected value=%0d error=%s,",
                     $realtime, results_checked,
                     (m_tdata_o !== want.total) ? " [value]" : "",
                     (m_tuser_o !== want.err) ? " [error]" : "",
                     $signed(want.total), want.err.name());
            $display("    got value=%0d error=%0d", $signed(m_tdata_o), m_tuser_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void add_char(ref char_q_t text, input logic [CharW-1:0] ch);
    text.insert(text.size(), ch);
  endfunction

  function automatic void append_text(ref char_q_t text, input string s);
    for (int i = 0; i < s.len(); i++) add_char(text, s[i]);
  endfunction

  function automatic logic [CharW-1:0] pick_operator();
    logic [CharW-1:0] ch;
    case ($urandom_range(0, 8))
      0, 1:    return ChPlus;
      2, 3:    return ChMinus;
      4, 5:    return ChStar;
      6, 7:    return ChSlash;
      default: begin
        do ch = CharW'($urandom_range(0, 255)); while (ch >= ChZero && ch <= ChNine);
        return ch;
      end
    endcase
  endfunction

  // Mostly short numbers, some full 32-bit ones and the range boundaries.
  function automatic void append_number(ref char_q_t text, input bit force_zero);
    longint unsigned num;
    int unsigned     pick;
    pick = $urandom_range(99);
    if (force_zero) num = 0;
    else if (pick < 55) num = 64'($urandom_range(0, 99));
    else if (pick < 75) num = 64'($urandom_range(0, 99999));
    else if (pick < 88) num = 64'($urandom);
    else begin
      case ($urandom_range(0, 3))
        0:       num = 0;
        1:       num = 64'd2147483647;
        2:       num = 64'd2147483648;
        default: num = 64'd99999999999;
      endcase
    end
    if ($urandom_range(99) < 8) add_char(text, ChZero);
    append_text(text, $sformatf("%0d", num));
  endfunction

  // Well-formed expression with random content, sometimes broken or pure noise.
  function automatic char_q_t random_expression();
    char_q_t          text;
    int unsigned      terms;
    int unsigned      form;
    logic [CharW-1:0] op;
    terms = $urandom_range(1, 4);
    op    = ChPlus;
    for (int t = 0; t < terms; t++) begin
      if (t > 0) begin
        op = pick_operator();
        add_char(text, op);
      end
      append_number(text, t > 0 && op == ChSlash && $urandom_range(99) < 10);
    end
    form = $urandom_range(99);
    if (form < 8) begin
      text = {};
      repeat ($urandom_range(1, 10)) add_char(text, CharW'($urandom_range(0, 255)));
    end else if (form < 12) begin
      add_char(text, pick_operator());
    end else if (form < 16) begin
      text.push_front(pick_operator());
    end else if (form < 22) begin
      text.insert($urandom_range(0, text.size()), pick_operator());
    end
    return text;
  endfunction

  // Top of the range with wrap on add, and a lone zero.
  task automatic test_number_extremes();
    char_q_t text;
    append_text(text, "2147483647+1");
    send_expression(text);
    text = {};
    append_text(text, "0");
    send_expression(text);
  endtask

  // Subtract, multiply and divide in one chain, negative truncation, ignored number.
  task automatic test_operator_chain();
    char_q_t text;
    append_text(text, "3-10*3/4");
    add_char(text, 8'h00);
    add_char(text, "9");
    send_expression(text);
  endtask

  // Leading and trailing operators, too-large number, divide by zero
  // followed by a second error that must not override it.
  task automatic test_error_cases();
    char_q_t text;
    append_text(text, "+");
    send_expression(text);
    text = {};
    append_text(text, "1+");
    send_expression(text);
    text = {};
    append_text(text, "2147483648");
    send_expression(text);
    text = {};
    append_text(text, "4/0+");
    send_expression(text);
  endtask

  task automatic test_random_traffic(input int n_chars);
    int start;
    start = chars_sent;
    while (chars_sent - start < n_chars) send_expression(random_expression());
  endtask

  // Stall the receiver for a long stretch while short expressions keep
  // coming, so the output register fills and the input side backs up.
  task automatic test_output_backpressure();
    char_q_t text;
    send_idle_pct = 0;
    hold_cycles   = HoldOffCycles;
    repeat (16) begin
      text = {};
      append_number(text, 1'b0);
      add_char(text, pick_operator());
      append_number(text, 1'b0);
      send_expression(text);
    end
  endtask

  initial begin
    clear_expression();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 17;
    recv_idle_pct = 57;
    test_number_extremes();
    test_operator_chain();
    test_error_cases();
    test_random_traffic(580);

    send_idle_pct = 57;
    recv_idle_pct = 17;
    test_random_traffic(580);

    test_output_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(560);

    // Drop valid, drain outstanding results, then allow the pipeline to settle.
    s_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d characters, checked %0d results: ok %0d, malformed %0d,",
             chars_sent, results_checked, err_seen[ERR_NONE], err_seen[ERR_MALFORMED]);
    $display("too large %0d, divide by zero %0d", err_seen[ERR_RANGE],
             err_seen[ERR_DIVZERO]);
    $display("Idle mixes 17/57, 57/17 and none, plus a %0d-cycle receiver hold; %0d mismatches",
             HoldOffCycles, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== left_to_right_integer_expression.f =====
src/ltrie_pkg.sv
src/ltrie_div.sv
src/ltrie_dp.sv
src/ltrie_ctrl.sv
src/left_to_right_integer_expression.sv
verif/tb_top.sv
